### hdl/sdft_pkg.sv
// Shared types, constants and constant tables of the sliding DFT spectrum analyser.
// Twiddle and Hann window tables are built at elaboration from an integer Taylor series.
// No dependencies.
package sdft_pkg;

   localparam int FFT_SIZE  = 64;
   localparam int FFT_LOG2  = 6;
   localparam int NUM_BINS  = FFT_SIZE / 2 + 1;
   localparam int IDX_W     = 6;
   localparam int HOP_W     = 7;
   localparam int RATE_W    = 18;
   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 16;
   localparam int TWID_W    = 17;
   localparam int ACC_W     = 53;
   localparam int NUM_BANDS = 3;
   localparam int DIVD_W    = 21;

   localparam logic [0:0] REG_HOP_SIZE    = 1'b0;
   localparam logic [0:0] REG_SAMPLE_RATE = 1'b1;

   localparam logic [HOP_W-1:0]  HOP_RESET  = 7'd32;
   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

   localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -16'sd25600;
   localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;

   typedef logic [DIVD_W-1:0] band_tab_type [NUM_BANDS];
   // band edge frequency times FFT_SIZE, divided by the sample rate at run time
   localparam band_tab_type BAND_LO_SCALED = '{
      21'(20 * FFT_SIZE), 21'(250 * FFT_SIZE), 21'(4000 * FFT_SIZE)};
   localparam band_tab_type BAND_HI_SCALED = '{
      21'(250 * FFT_SIZE), 21'(4000 * FFT_SIZE), 21'(20000 * FFT_SIZE)};

   typedef struct packed {
      logic                        done;
      logic signed [LEVEL_W-1:0]   level;
   } level_rsp_type;

   typedef logic signed [TWID_W-1:0] twid_tab_type [FFT_SIZE];
   typedef logic [TWID_W-1:0]        win_tab_type  [FFT_SIZE];

   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] TAYLOR_D1  = 64'd6;
   localparam logic [63:0] TAYLOR_D2  = 64'd20;
   localparam logic [63:0] TAYLOR_D3  = 64'd42;
   localparam logic [63:0] TAYLOR_D4  = 64'd72;
   localparam logic [63:0] TAYLOR_D5  = 64'd110;
   localparam logic [63:0] TAYLOR_D6  = 64'd156;
   localparam logic [63:0] COS_TURNS  = 64'(4 * FFT_SIZE);
   localparam logic [63:0] WIN_TURNS  = 64'(4 * (FFT_SIZE - 1));

   // sine of a Q32 fraction of a turn, Q1.15
   function automatic logic signed [TWID_W-1:0] sin_q32(input logic [63:0] t);
      logic [1:0]  quad;
      logic [63:0] f, r, r2, term, pos, neg, v;
      quad = t[31:30];
      f    = {34'd0, t[29:0]};
      if (quad[0]) f = Q30_ONE - f;
      r    = (f * TWO_PI_Q30) >> 32;
      r2   = (r * r) >> 30;
      term = r;
      pos  = r;
      neg  = 64'd0;
      term = ((term * r2) >> 30) / TAYLOR_D1; neg = neg + term;
      term = ((term * r2) >> 30) / TAYLOR_D2; pos = pos + term;
      term = ((term * r2) >> 30) / TAYLOR_D3; neg = neg + term;
      term = ((term * r2) >> 30) / TAYLOR_D4; pos = pos + term;
      term = ((term * r2) >> 30) / TAYLOR_D5; neg = neg + term;
      term = ((term * r2) >> 30) / TAYLOR_D6; pos = pos + term;
      v = (pos > neg) ? pos - neg : 64'd0;
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      return quad[1] ? -$signed(TWID_W'(v)) : $signed(TWID_W'(v));
   endfunction

   function automatic twid_tab_type build_cos();
      twid_tab_type tab;
      logic [63:0]  p;
      for (int i = 0; i < FFT_SIZE; i++) begin
         p = (64'(4 * i) + 64'(FFT_SIZE)) % COS_TURNS;
         tab[i] = sin_q32((p << 32) / COS_TURNS);
      end
      return tab;
   endfunction

   function automatic twid_tab_type build_sin();
      twid_tab_type tab;
      for (int i = 0; i < FFT_SIZE; i++) begin
         tab[i] = sin_q32((64'(4 * i) << 32) / COS_TURNS);
      end
      return tab;
   endfunction

   // Hann window, denominator N-1, 0..32768
   function automatic win_tab_type build_win();
      win_tab_type              tab;
      logic [63:0]              p;
      logic signed [TWID_W:0]   c;
      logic signed [TWID_W:0]   d;
      for (int i = 0; i < FFT_SIZE; i++) begin
         p = (64'(4 * i) + 64'(FFT_SIZE - 1)) % WIN_TURNS;
         c = (TWID_W + 1)'(sin_q32((p << 32) / WIN_TURNS));
         d = 18'sd32768 - c;
         tab[i] = TWID_W'(d >>> 1);
      end
      return tab;
   endfunction

   localparam twid_tab_type COS_TAB = build_cos();
   localparam twid_tab_type SIN_TAB = build_sin();
   localparam win_tab_type  WIN_TAB = build_win();

endpackage

### hdl/sdft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sdft_level.sv
// Bin level unit: |X|^2 -> Q16 log2 by repeated squaring -> dB in Q8.8, one shared multiplier.
// Depends on sdft_pkg.
module sdft_level #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [sdft_pkg::ACC_W-1:0]    re,
   input  logic signed [sdft_pkg::ACC_W-1:0]    im,
   output sdft_pkg::level_rsp_type              rsp
);

   localparam int MAG_W      = sdft_pkg::ACC_W - 1;
   localparam int LOG_OFFSET = (2 * (SAMPLE_BITS - 1 + 30) + 2 * sdft_pkg::FFT_LOG2) * 65536;

   localparam logic [3:0] L_IDLE    = 4'd0;
   localparam logic [3:0] L_SHIFT   = 4'd1;
   localparam logic [3:0] L_SQ_RE   = 4'd2;
   localparam logic [3:0] L_SQ_IM   = 4'd3;
   localparam logic [3:0] L_SUM     = 4'd4;
   localparam logic [3:0] L_NORM    = 4'd5;
   localparam logic [3:0] L_LOGMUL  = 4'd6;
   localparam logic [3:0] L_LOGSTEP = 4'd7;
   localparam logic [3:0] L_DB      = 4'd8;
   localparam logic [3:0] L_RND     = 4'd9;

   logic [3:0]        state_ff;
   logic              done_ff;
   logic [MAG_W-1:0]  ure_ff, uim_ff;
   logic [4:0]        shift_ff;
   logic [61:0]       prod_ff, prod_in;
   logic [62:0]       e_ff;
   logic [5:0]        ex_ff;
   logic [30:0]       y_ff;
   logic [15:0]       frac_ff;
   logic [3:0]        it_ff;
   logic              neg_ff;
   logic signed [15:0] level_ff;

   logic [30:0]        mul_a, mul_b;
   logic [23:0]        lpos;
   logic signed [24:0] ltot;
   logic [23:0]        lmag;
   logic [31:0]        tsq;
   logic [42:0]        rnd;
   logic [17:0]        dbmag;

   assign lpos = 24'({ex_ff, 16'd0}) + 24'(frac_ff) + 24'({shift_ff, 17'd0});
   assign ltot = $signed({1'b0, lpos}) - 25'(LOG_OFFSET);
   assign lmag = ltot[24] ? 24'(-ltot) : 24'(ltot);
   assign tsq  = prod_ff[61:30];
   assign rnd  = 43'(prod_ff[41:0]) + 43'd8388608;
   assign dbmag = rnd[41:24];

   always_comb begin
      case (state_ff)
         L_SQ_RE:  begin mul_a = ure_ff[30:0]; mul_b = ure_ff[30:0]; end
         L_SQ_IM:  begin mul_a = uim_ff[30:0]; mul_b = uim_ff[30:0]; end
         L_LOGMUL: begin mul_a = y_ff;         mul_b = y_ff;         end
         L_DB:     begin mul_a = 31'(lmag);    mul_b = 31'(sdft_pkg::DB_PER_LOG2_Q16); end
         default:  begin mul_a = '0;           mul_b = '0;           end
      endcase
   end

   assign prod_in = 62'(mul_a) * 62'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  ure_ff   <= re[sdft_pkg::ACC_W-1] ? MAG_W'(-re) : MAG_W'(re);
                  uim_ff   <= im[sdft_pkg::ACC_W-1] ? MAG_W'(-im) : MAG_W'(im);
                  shift_ff <= 5'd0;
                  state_ff <= L_SHIFT;
               end
            end
            L_SHIFT: begin
               // bring the larger part under 2^31
               if (|(ure_ff[MAG_W-1:31] | uim_ff[MAG_W-1:31])) begin
                  ure_ff   <= ure_ff >> 1;
                  uim_ff   <= uim_ff >> 1;
                  shift_ff <= shift_ff + 5'd1;
               end else begin
                  state_ff <= L_SQ_RE;
               end
            end
            L_SQ_RE: state_ff <= L_SQ_IM;
            L_SQ_IM: begin
               e_ff     <= 63'(prod_ff);
               state_ff <= L_SUM;
            end
            L_SUM: begin
               e_ff     <= e_ff + 63'(prod_ff);
               ex_ff    <= 6'd62;
               state_ff <= L_NORM;
            end
            L_NORM: begin
               if (e_ff == '0) begin
                  level_ff <= sdft_pkg::LEVEL_FLOOR;
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else if (e_ff[62:55] == 8'd0) begin
                  e_ff  <= e_ff << 8;
                  ex_ff <= ex_ff - 6'd8;
               end else if (!e_ff[62]) begin
                  e_ff  <= e_ff << 1;
                  ex_ff <= ex_ff - 6'd1;
               end else begin
                  y_ff     <= e_ff[62:32];
                  frac_ff  <= 16'd0;
                  it_ff    <= 4'd0;
                  state_ff <= L_LOGMUL;
               end
            end
            L_LOGMUL: state_ff <= L_LOGSTEP;
            L_LOGSTEP: begin
               frac_ff <= {frac_ff[14:0], tsq[31]};
               y_ff    <= tsq[31] ? tsq[31:1] : tsq[30:0];
               it_ff   <= it_ff + 4'd1;
               state_ff <= (it_ff == 4'd15) ? L_DB : L_LOGMUL;
            end
            L_DB: begin
               neg_ff   <= ltot[24];
               state_ff <= L_RND;
            end
            L_RND: begin
               if (!neg_ff)
                  level_ff <= '0;
               else if (dbmag >= 18'd25600)
                  level_ff <= sdft_pkg::LEVEL_FLOOR;
               else
                  level_ff <= -$signed(16'(dbmag));
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.level = level_ff;

endmodule

### hdl/sliding_dft_spectrum_analyzer.sv
// Sliding DFT spectrum analyser: top level, sequencer, MAC datapath and shared serial divider.
// A sample beat that does not complete a hop only stores the sample. A hop runs six band-edge
// divisions, then per bin a MAC pass over the window through the pipeline, the level unit
// (which ends early on a silent bin) and the result load, then up to three band-mean divisions,
// plus any result stalls; the single MAC and the serial level unit serve every bin in turn.
// Reset is synchronous: registers return to their defaults, history reads as zero via valid
// bits, so no clearing pass is needed. Depends on sdft_pkg, sdft_ram and sdft_level.
module sliding_dft_spectrum_analyzer #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [5:0] bin_index, [21:6] level_db, [37:22] low_band_db,
                                    // [53:38] mid_band_db, [69:54] high_band_db, [71:70] zero
   output logic        rsp_tlast,   // last_bin
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [17:0] csr_data
);

   localparam int N    = sdft_pkg::FFT_SIZE;
   localparam int IW   = sdft_pkg::IDX_W;
   localparam int IN_W = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EDGE  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_LEVEL = 3'd3;
   localparam logic [2:0] S_MEAN  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [IW-1:0] LAST_BIN = IW'(sdft_pkg::NUM_BINS - 1);

   // ---------------- registers ----------------
   logic [2:0]               state_ff;
   logic [6:0]               hop_ff;
   logic [17:0]              rate_ff;
   logic [IW-1:0]            ptr_ff;
   logic [6:0]               cnt_ff;
   logic [N-1:0]             hist_vld_ff;

   logic [IW-1:0]            bin_ff, n_ff, m_ff;
   logic                     issue_ff;
   // MAC pipeline: read, window product, twiddle products, accumulate
   logic                     v1_ff, l1_ff, vld1_ff;
   logic [IW-1:0]            m1_ff;
   logic [sdft_pkg::TWID_W-1:0] win1_ff;
   logic                     v2_ff, l2_ff;
   logic [IW-1:0]            m2_ff;
   logic signed [32:0]       xw2_ff;
   logic                     v3_ff, l3_ff;
   logic signed [49:0]       re3_ff, im3_ff;
   logic                     fin4_ff;
   logic signed [sdft_pkg::ACC_W-1:0] acc_re_ff, acc_im_ff;

   // serial restoring divider, one quotient bit a cycle
   logic                     div_run_ff;
   logic [4:0]               div_cnt_ff;
   logic [17:0]              div_rem_ff, div_den_ff;
   logic [20:0]              div_quo_ff;

   logic [2:0]               edge_ff;
   logic [1:0]               mj_ff;
   logic [6:0]               lo_ff   [sdft_pkg::NUM_BANDS];
   logic [IW-1:0]            hi_ff   [sdft_pkg::NUM_BANDS];
   logic signed [21:0]       sum_ff  [sdft_pkg::NUM_BANDS];
   logic signed [15:0]       mean_ff [sdft_pkg::NUM_BANDS];

   logic                     rsp_valid_ff, rsp_last_ff;
   logic [IW-1:0]            rsp_bin_ff;
   logic signed [15:0]       rsp_level_ff, rsp_low_ff, rsp_mid_ff, rsp_high_ff;

   // ---------------- combinational ----------------
   logic                     req_acc, csr_acc;
   logic [6:0]               hop_eff, cnt_in;
   logic [17:0]              rate_eff;
   logic signed [15:0]       x_in;
   logic [IW-1:0]            rd_addr;
   logic [15:0]              rd_data;
   logic signed [15:0]       x2;
   logic [18:0]              div_trial, div_diff;
   logic                     div_ge, div_done;
   logic [1:0]               eband;
   logic [20:0]              edge_divd;
   logic                     band_empty;
   logic [6:0]               band_cnt;
   logic                     lvl_start;
   sdft_pkg::level_rsp_type  lvl_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;

   // hop 0 acts as 1, beyond the window acts as the window length
   assign hop_eff  = (hop_ff == 7'd0) ? 7'd1 : ((hop_ff > 7'(N)) ? 7'(N) : hop_ff);
   assign rate_eff = (rate_ff == 18'd0) ? 18'd1 : rate_ff;
   assign cnt_in   = cnt_ff + 7'd1;
   assign x_in     = 16'($signed(req_tdata[IN_W-1:0]));

   // oldest sample first: the write pointer already points past the newest
   assign rd_addr = ptr_ff + n_ff;
   assign x2      = vld1_ff ? $signed(rd_data) : 16'sd0;

   assign div_trial = {div_rem_ff, div_quo_ff[20]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});
   assign div_done  = div_run_ff && (div_cnt_ff == 5'd0);

   assign eband     = edge_ff[2:1];
   assign edge_divd = edge_ff[0] ? sdft_pkg::BAND_HI_SCALED[eband]
                                 : sdft_pkg::BAND_LO_SCALED[eband];
   assign band_empty = ({1'b0, hi_ff[mj_ff]} < lo_ff[mj_ff]);
   assign band_cnt   = {1'b0, hi_ff[mj_ff]} - lo_ff[mj_ff] + 7'd1;

   assign lvl_start = (state_ff == S_MAC) && fin4_ff;

   sdft_ram #(
      .WIDTH (16),
      .DEPTH (N)
   ) u_hist (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (ptr_ff),
      .wr_data (x_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sdft_level #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_level (
      .clock (clock),
      .reset (reset),
      .start (lvl_start),
      .re    (acc_re_ff),
      .im    (acc_im_ff),
      .rsp   (lvl_rsp)
   );

   // ---------------- MAC datapath (no reset) ----------------
   always_ff @(posedge clock) begin
      vld1_ff <= hist_vld_ff[rd_addr];
      m1_ff   <= m_ff;
      win1_ff <= sdft_pkg::WIN_TAB[n_ff];
      m2_ff   <= m1_ff;
      xw2_ff  <= 33'(x2) * 33'($signed({1'b0, win1_ff}));
      re3_ff  <= 50'(xw2_ff) * 50'(sdft_pkg::COS_TAB[m2_ff]);
      im3_ff  <= 50'(xw2_ff) * 50'(sdft_pkg::SIN_TAB[m2_ff]);
      if (state_ff != S_MAC) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v3_ff) begin
         acc_re_ff <= acc_re_ff + sdft_pkg::ACC_W'(re3_ff);
         acc_im_ff <= acc_im_ff - sdft_pkg::ACC_W'(im3_ff);
      end
   end

   // ---------------- sequencer and control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hop_ff       <= sdft_pkg::HOP_RESET;
         rate_ff      <= sdft_pkg::RATE_RESET;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         hist_vld_ff  <= '0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         fin4_ff      <= 1'b0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_acc) begin
            unique case (csr_index)
               sdft_pkg::REG_HOP_SIZE:    hop_ff  <= csr_data[6:0];
               sdft_pkg::REG_SAMPLE_RATE: rate_ff <= csr_data;
            endcase
         end

         // S_OUT reloads the result register itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         // pipeline tags
         v1_ff   <= issue_ff;
         l1_ff   <= (n_ff == IW'(N - 1));
         v2_ff   <= v1_ff;
         l2_ff   <= l1_ff;
         v3_ff   <= v2_ff;
         l3_ff   <= l2_ff;
         fin4_ff <= v3_ff && l3_ff;
         if (issue_ff) begin
            n_ff <= n_ff + IW'(1);
            m_ff <= m_ff + bin_ff;
            if (n_ff == IW'(N - 1)) issue_ff <= 1'b0;
         end

         // divider step
         if (div_run_ff && div_cnt_ff != 5'd0) begin
            div_rem_ff <= div_ge ? div_diff[17:0] : div_trial[17:0];
            div_quo_ff <= {div_quo_ff[19:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 5'd1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  hist_vld_ff[ptr_ff] <= 1'b1;
                  ptr_ff <= ptr_ff + IW'(1);
                  if (cnt_in >= hop_eff) begin
                     cnt_ff   <= '0;
                     edge_ff  <= '0;
                     for (int b = 0; b < sdft_pkg::NUM_BANDS; b++) sum_ff[b] <= '0;
                     state_ff <= S_EDGE;
                  end else begin
                     cnt_ff <= cnt_in;
                  end
               end
            end
            S_EDGE: begin
               // band edges: floor(f * N / rate), six divisions
               if (!div_run_ff) begin
                  div_run_ff <= 1'b1;
                  div_cnt_ff <= 5'd21;
                  div_rem_ff <= '0;
                  div_quo_ff <= edge_divd;
                  div_den_ff <= rate_eff;
               end else if (div_done) begin
                  div_run_ff <= 1'b0;
                  if (edge_ff[0])
                     hi_ff[eband] <= (div_quo_ff > 21'(LAST_BIN)) ? LAST_BIN : div_quo_ff[IW-1:0];
                  else
                     lo_ff[eband] <= (div_quo_ff > 21'd127) ? 7'd127 : div_quo_ff[6:0];
                  if (edge_ff == 3'd5) begin
                     bin_ff   <= '0;
                     n_ff     <= '0;
                     m_ff     <= '0;
                     issue_ff <= 1'b1;
                     state_ff <= S_MAC;
                  end else begin
                     edge_ff <= edge_ff + 3'd1;
                  end
               end
            end
            S_MAC: begin
               if (fin4_ff) state_ff <= S_LEVEL;
            end
            S_LEVEL: begin
               if (lvl_rsp.done) begin
                  for (int b = 0; b < sdft_pkg::NUM_BANDS; b++) begin
                     if ({1'b0, bin_ff} >= lo_ff[b] && bin_ff <= hi_ff[b])
                        sum_ff[b] <= sum_ff[b] + 22'(lvl_rsp.level);
                  end
                  mj_ff    <= '0;
                  state_ff <= (bin_ff == LAST_BIN) ? S_MEAN : S_OUT;
               end
            end
            S_MEAN: begin
               // band means: sum / count, truncated toward zero (sums are never positive)
               if (band_empty) begin
                  mean_ff[mj_ff] <= '0;
                  if (mj_ff == 2'd2) state_ff <= S_OUT;
                  else mj_ff <= mj_ff + 2'd1;
               end else if (!div_run_ff) begin
                  div_run_ff <= 1'b1;
                  div_cnt_ff <= 5'd21;
                  div_rem_ff <= '0;
                  div_quo_ff <= 21'(-sum_ff[mj_ff]);
                  div_den_ff <= 18'(band_cnt);
               end else if (div_done) begin
                  div_run_ff     <= 1'b0;
                  mean_ff[mj_ff] <= -$signed(16'(div_quo_ff));
                  if (mj_ff == 2'd2) state_ff <= S_OUT;
                  else mj_ff <= mj_ff + 2'd1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bin_ff   <= bin_ff;
                  rsp_level_ff <= lvl_rsp.level;
                  rsp_last_ff  <= (bin_ff == LAST_BIN);
                  rsp_low_ff   <= (bin_ff == LAST_BIN) ? mean_ff[0] : 16'sd0;
                  rsp_mid_ff   <= (bin_ff == LAST_BIN) ? mean_ff[1] : 16'sd0;
                  rsp_high_ff  <= (bin_ff == LAST_BIN) ? mean_ff[2] : 16'sd0;
                  if (bin_ff == LAST_BIN) begin
                     state_ff <= S_IDLE;
                  end else begin
                     bin_ff   <= bin_ff + IW'(1);
                     n_ff     <= '0;
                     m_ff     <= '0;
                     issue_ff <= 1'b1;
                     state_ff <= S_MAC;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_high_ff, rsp_mid_ff, rsp_low_ff, rsp_level_ff, rsp_bin_ff};

endmodule

### dv/tb_top.sv
// Self-checking bench for sliding_dft_spectrum_analyzer: sample beats in, spectrum bins out.
// Holds its own bit-exact model of the windowed DFT and the dB conversion in a small class.
// Depends on sdft_pkg for the register index names.
`timescale 1ns / 100ps
module tb_top;

   localparam int N     = 64;
   localparam int NB    = N / 2 + 1;
   localparam longint unsigned Q30 = 64'd1073741824;

   typedef struct {
      logic [5:0]          bin;
      logic signed [15:0]  level;
      logic                last;
      logic signed [15:0]  low_db;
      logic signed [15:0]  mid_db;
      logic signed [15:0]  high_db;
   } bin_beat_type;

   // Spectrum model plus queue of bins still owed by the block
   class spectrum_board;
      int                  cos_tab[N];
      int                  sin_tab[N];
      int                  win_tab[N];
      longint              log2_n;
      int unsigned         hop_reg;
      int unsigned         rate_reg;
      int                  history[N];
      int unsigned         wr_ptr;
      int unsigned         since_frame;
      int                  levels[NB];
      bin_beat_type        owed[$];
      int                  errors;
      int                  frames;
      int                  bins_seen;

      function new();
         for (int i = 0; i < N; i++) begin
            cos_tab[i] = cos_turns(i, N);
            sin_tab[i] = sin_turns(i, N);
            win_tab[i] = (32768 - cos_turns(i, N - 1)) >>> 1;
         end
         log2_n = log2_q16(N);
         hop_reg = 32;
         rate_reg = 48000;
         foreach (history[i]) history[i] = 0;
         wr_ptr = 0;
         since_frame = 0;
         errors = 0;
         frames = 0;
         bins_seen = 0;
      endfunction

      // Q1.15 sine of p/q turns, integer Taylor series on Q30 radians
      function int sin_turns(int unsigned p, int unsigned q);
         longint unsigned t, f, r, r2, term, pos, neg, v;
         int unsigned     quad;
         t    = (longint'(p % q) << 32) / q;
         quad = 32'((t >> 30) & 3);
         f    = t & (Q30 - 1);
         if (quad & 1) f = Q30 - f;
         r    = (f * 64'd6746518852) >> 32;
         r2   = (r * r) >> 30;
         term = r;
         pos  = r;
         neg  = 0;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * r2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) neg += term;
            else pos += term;
         end
         v = (pos > neg) ? pos - neg : 0;
         v = (v + 16384) >> 15;
         if (v > 32768) v = 32768;
         return (quad >= 2) ? -int'(v) : int'(v);
      endfunction

      function int cos_turns(int unsigned p, int unsigned q);
         return sin_turns(4 * (p % q) + q, 4 * q);
      endfunction

      function longint log2_q16(longint unsigned v);
         int unsigned     e;
         longint unsigned y, frac;
         e = 0;
         frac = 0;
         while (e < 63 && (v >> (e + 1)) != 0) e++;
         y = (e > 30) ? v >> (e - 30) : v << (30 - e);
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= 2 * Q30) begin
               frac |= 1;
               y = y >> 1;
            end
         end
         return longint'((longint'(e) << 16) + frac);
      endfunction

      function int level_db(longint re, longint im);
         longint unsigned ure, uim, m, en;
         int unsigned     s;
         longint          ltot, db;
         ure = (re < 0) ? -re : re;
         uim = (im < 0) ? -im : im;
         m   = (ure > uim) ? ure : uim;
         s   = 0;
         while ((m >> s) >= 64'd2147483648) s++;
         ure = ure >> s;
         uim = uim >> s;
         en  = ure * ure + uim * uim;
         if (en == 0) return -25600;
         ltot = log2_q16(en) + longint'(s) * 2 * 65536 - 2 * (15 + 30) * 65536 - 2 * log2_n;
         if (ltot < 0) db = -longint'((longint'(-ltot) * 197283 + 8388608) >> 24);
         else db = longint'((longint'(ltot) * 197283 + 8388608) >> 24);
         if (db < -25600) db = -25600;
         if (db > 0) db = 0;
         return int'(db);
      endfunction

      // mean over bins floor(f*N/rate), hi clamped to N/2; empty band reads 0
      function int band_mean(int unsigned f_lo, int unsigned f_hi);
         int unsigned rate, lo, hi;
         int          acc;
         rate = (rate_reg != 0) ? rate_reg : 1;
         lo   = f_lo * N / rate;
         hi   = f_hi * N / rate;
         acc  = 0;
         if (hi > NB - 1) hi = NB - 1;
         if (hi < lo) return 0;
         for (int unsigned i = lo; i <= hi; i++) acc += levels[i];
         return acc / int'(hi - lo + 1);
      endfunction

      function void set_reg(logic [0:0] idx, logic [17:0] value);
         if (idx == sdft_pkg::REG_HOP_SIZE) hop_reg = 32'(value & 18'h7f);
         else rate_reg = 32'(value);
      endfunction

      function void note_sample(logic signed [15:0] smp);
         int unsigned  hop;
         longint       xw[N];
         longint       re, im;
         bin_beat_type b;
         hop = (hop_reg == 0) ? 1 : ((hop_reg > N) ? N : hop_reg);
         history[wr_ptr] = 32'(smp);
         wr_ptr = (wr_ptr + 1) % N;
         since_frame = (since_frame + 1) & 7'h7f;
         if (since_frame < hop) return;
         since_frame = 0;
         frames++;
         // oldest sample meets window tap 0
         for (int n = 0; n < N; n++)
            xw[n] = longint'(history[(wr_ptr + n) % N]) * win_tab[n];
         for (int k = 0; k < NB; k++) begin
            re = 0;
            im = 0;
            for (int n = 0; n < N; n++) begin
               re += xw[n] * cos_tab[(k * n) % N];
               im -= xw[n] * sin_tab[(k * n) % N];
            end
            levels[k] = level_db(re, im);
         end
         for (int k = 0; k < NB; k++) begin
            b.bin     = 6'(k);
            b.level   = 16'(levels[k]);
            b.last    = (k == NB - 1);
            b.low_db  = b.last ? 16'(band_mean(20, 250)) : 16'sd0;
            b.mid_db  = b.last ? 16'(band_mean(250, 4000)) : 16'sd0;
            b.high_db = b.last ? 16'(band_mean(4000, 20000)) : 16'sd0;
            owed.push_back(b);
         end
      endfunction

      function void check_bin(bin_beat_type got);
         bin_beat_type want;
         bins_seen++;
         if (owed.size() == 0) begin
            $error("unexpected bin beat: bin_index %0d", got.bin);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.bin !== want.bin) begin
            $error("bin_index: expected %0d, got %0d", want.bin, got.bin); errors++;
         end
         if (got.level !== want.level) begin
            $error("level_db: expected %0d, got %0d", want.level, got.level); errors++;
         end
         if (got.last !== want.last) begin
            $error("last_bin: expected %0d, got %0d", want.last, got.last); errors++;
         end
         if (got.low_db !== want.low_db) begin
            $error("low_band_db: expected %0d, got %0d", want.low_db, got.low_db); errors++;
         end
         if (got.mid_db !== want.mid_db) begin
            $error("mid_band_db: expected %0d, got %0d", want.mid_db, got.mid_db); errors++;
         end
         if (got.high_db !== want.high_db) begin
            $error("high_band_db: expected %0d, got %0d", want.high_db, got.high_db);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [17:0] csr_data;

   spectrum_board board;
   bit            no_idle;
   int            samples_sent;

   sliding_dft_spectrum_analyzer dut (.*);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Hard stop well past the slowest legal run (every beat a full hop)
   initial begin
      #100ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Sample sender; valid stays up across back-to-back beats
   task automatic send_sample(input logic signed [15:0] smp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      board.note_sample(smp);
      samples_sent++;
   endtask

   // Drop valid, let every owed bin drain, then allow the block to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [17:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Result side: random back-pressure between bin beats
   initial begin
      bin_beat_type got;
      int           stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.bin     = rsp_tdata[5:0];
            got.level   = rsp_tdata[21:6];
            got.low_db  = rsp_tdata[37:22];
            got.mid_db  = rsp_tdata[53:38];
            got.high_db = rsp_tdata[69:54];
            got.last    = rsp_tlast;
            board.check_bin(got);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      // hop (raw 7-bit value, upper data bits random), rate, sample count
      int             hops[9]  = '{64, 127, 7, 17, 48, 3, 0, 32, 5};
      int             rates[9] = '{192000, 262143, 44100, 8000, 96000, 20000, 0, 48000, 1000};
      int             counts[9] = '{80, 70, 60, 40, 50, 20, 4, 50, 20};
      logic signed [15:0] directed[12] = '{16'sh7fff, -16'sh8000, -16'sd1, 16'sd1,
                                           16'sh5555, -16'sh5556, 16'sh7fff, -16'sh8000,
                                           16'sh00ff, -16'sh0100, 16'sh4000, 16'sd0};
      logic signed [15:0] smp;
      int             mode, period, phase_ctr, amp;
      board = new();
      no_idle    = 1'b0;
      samples_sent = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= sdft_pkg::REG_HOP_SIZE;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: hop of one; the first frame is silent history, so every bin hits the floor
      write_reg(sdft_pkg::REG_HOP_SIZE, 18'd1);
      send_sample(16'sd0);
      foreach (directed[i]) send_sample(directed[i]);
      drain();
      // full-scale DC across a whole window, with the hop set to the window length
      write_reg(sdft_pkg::REG_HOP_SIZE, 18'd64);
      repeat (64) send_sample(16'sh7fff);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         write_reg(sdft_pkg::REG_HOP_SIZE, {11'($urandom_range(0, 2047)), 7'(hops[ph])});
         write_reg(sdft_pkg::REG_SAMPLE_RATE, 18'(rates[ph]));
         no_idle = (ph % 3 == 2);
         period = $urandom_range(2, 20);
         amp = $urandom_range(0, 15);
         phase_ctr = 0;
         for (int i = 0; i < counts[ph]; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
               // square tone: random period and amplitude
               smp = (phase_ctr < period / 2) ? 16'((1 << amp) - 1) : 16'(-(1 << amp));
               phase_ctr = (phase_ctr + 1) % period;
            end else if (mode < 7) begin
               smp = 16'($urandom);
            end else if (mode < 9) begin
               smp = 16'($signed($urandom_range(0, 65535)) >>> $urandom_range(4, 15));
            end else begin
               smp = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            end
            send_sample(smp);
         end
         drain();
      end

      repeat (200) @(posedge clock);
      $display("Run covered %0d samples over 11 register settings, %0d frames, %0d bins checked.",
               samples_sent, board.frames, board.bins_seen);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
